[rtl/core/lbp_pkg.sv]
`timescale 1ns / 1ps

package lbp_pkg;

	// PWM resolution; every duty target is clamped to full scale
	localparam int DUTY_BITS = 8;
	localparam int FULL_DUTY_INT = ((1 << DUTY_BITS) - 1) > 255 ? 255 : ((1 << DUTY_BITS) - 1);
	localparam logic [7:0] FULL_DUTY = 8'(FULL_DUTY_INT);

	localparam logic [5:0] FADE_BREATH  = 6'd50;
	localparam logic [5:0] FADE_RAINBOW = 6'd30;
	localparam logic [5:0] FADE_FLASH   = 6'd5;

	localparam logic [8:0] HUE_WRAP      = 9'd360;
	localparam logic [9:0] HUE_WRAP_TWICE = 10'd720;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_SET   = 2'd1,
		MODE_FLASH = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PAT_BREATH  = 2'd0,
		PAT_RAINBOW = 2'd1,
		PAT_FLASH   = 2'd2
	} pattern_t;

	typedef enum logic [2:0] {
		REG_BREATH_STEP  = 3'd0,
		REG_RAINBOW_STEP = 3'd1,
		REG_HUE_STEP     = 3'd2,
		REG_RAINBOW_MAX  = 3'd3,
		REG_RAINBOW_MIN  = 3'd4,
		REG_FLASH_SLICE  = 3'd5,
		REG_BREATH_PAUSE = 3'd6
	} cfg_reg_t;

	// 60 degree sectors of the hue circle, as seen by the green channel
	typedef enum logic [2:0] {
		SEXT_G_RISE   = 3'd0,
		SEXT_G_FULL_A = 3'd1,
		SEXT_G_FULL_B = 3'd2,
		SEXT_G_FALL   = 3'd3,
		SEXT_G_OFF_A  = 3'd4,
		SEXT_G_OFF_B  = 3'd5
	} hue_sext_t;

	typedef struct packed {
		hue_sext_t  sext;
		logic [7:0] frac; // (h mod 60) * 255 / 60
	} hue_pos_t;

	// split a hue below 360 into sector and scaled position in the sector
	function automatic hue_pos_t hue_split(input logic [8:0] h);
		hue_pos_t   res;
		logic [8:0] base;
		logic [5:0] rmd;
		logic [9:0] x17;
		if (h >= 9'd300) begin
			res.sext = SEXT_G_OFF_B; base = 9'd300;
		end else if (h >= 9'd240) begin
			res.sext = SEXT_G_OFF_A; base = 9'd240;
		end else if (h >= 9'd180) begin
			res.sext = SEXT_G_FALL; base = 9'd180;
		end else if (h >= 9'd120) begin
			res.sext = SEXT_G_FULL_B; base = 9'd120;
		end else if (h >= 9'd60) begin
			res.sext = SEXT_G_FULL_A; base = 9'd60;
		end else begin
			res.sext = SEXT_G_RISE; base = 9'd0;
		end
		rmd = 6'(h - base);
		// r * 255 / 60 == r * 17 / 4
		x17 = {rmd, 4'd0} + {4'd0, rmd};
		res.frac = x17[9:2];
		return res;
	endfunction

	function automatic logic [7:0] clamp_duty(input logic [7:0] d);
		return (d > FULL_DUTY) ? FULL_DUTY : d;
	endfunction

endpackage

[rtl/core/led_breathing_pattern_generator.sv]
// LED breathing / rainbow / flash pattern generator.
// A request accepted into the input register (s1) passes through the step logic into the
// result register (s2); it waits in s1 while out_stall holds a previous result in s2.
// Throughput: one request per cycle unless out_stall holds both pipeline registers full;
// a new request is taken into an empty input register while a finished result waits.
// Reset (arst_n low, asynchronous): pattern breathing, hue 0, brightness 128, rising,
// no flash time, registers at their defaults, both pipeline registers empty.
`timescale 1ns / 1ps

module led_breathing_pattern_generator (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [15:0] value,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  duty,
	output logic        duty_valid,
	output logic [5:0]  fade_ms,
	output logic [9:0]  hold_ms,
	output logic [1:0]  pattern_now,
	// register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [6:0] breath_step_q;
	logic [6:0] rainbow_step_q;
	logic [8:0] hue_step_q;
	logic [7:0] rainbow_max_q;
	logic [7:0] rainbow_min_q;
	logic [7:0] flash_slice_q;
	logic [9:0] breath_pause_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			breath_step_q  <= 7'd4;
			rainbow_step_q <= 7'd2;
			hue_step_q     <= 9'd3;
			rainbow_max_q  <= 8'd200;
			rainbow_min_q  <= 8'd30;
			flash_slice_q  <= 8'd50;
			breath_pause_q <= 10'd300;
		end else if (cfg_valid && cfg_ready) begin
			case (lbp_pkg::cfg_reg_t'(cfg_index))
				lbp_pkg::REG_BREATH_STEP:  breath_step_q  <= cfg_data[6:0];
				lbp_pkg::REG_RAINBOW_STEP: rainbow_step_q <= cfg_data[6:0];
				lbp_pkg::REG_HUE_STEP:     hue_step_q     <= cfg_data[8:0];
				lbp_pkg::REG_RAINBOW_MAX:  rainbow_max_q  <= cfg_data[7:0];
				lbp_pkg::REG_RAINBOW_MIN:  rainbow_min_q  <= cfg_data[7:0];
				lbp_pkg::REG_FLASH_SLICE:  flash_slice_q  <= cfg_data[7:0];
				lbp_pkg::REG_BREATH_PAUSE: breath_pause_q <= cfg_data;
				default: ; // unused index: write dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake: input register (s1) -> step logic -> result register (s2)
	// ---------------------------------------------------------------
	logic               in_v_s1;
	lbp_pkg::mode_t     mode_s1;
	logic [15:0]        value_s1;
	logic               out_v_s2;
	logic               adv;
	logic               in_acc;

	// s1 moves into s2 whenever s2 is empty or being drained this cycle
	assign adv      = in_v_s1 && (!out_v_s2 || !out_stall);
	assign in_stall = in_v_s1 && out_v_s2 && out_stall;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (in_acc) begin
			in_v_s1 <= 1'b1;
		end else if (adv) begin
			in_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1  <= lbp_pkg::mode_t'(mode);
			value_s1 <= value;
		end
	end

	// ---------------------------------------------------------------
	// Pattern state. The hue is kept alongside its sector and scaled
	// in-sector position so the duty path only needs one multiply.
	// ---------------------------------------------------------------
	lbp_pkg::pattern_t  pattern_q, pat_d;
	logic [8:0]         hue_q, hue_d;
	lbp_pkg::hue_pos_t  hpos_q, hpos_d;
	logic [7:0]         bright_q, bright_d;
	logic               up_q, up_d;
	logic [15:0]        flash_q, flash_d;

	// next hue, mod 360 (sum stays at most 359 + 511 = 870, under three full turns)
	logic [9:0] hue_sum;
	logic [9:0] hue_mod;
	logic [8:0] hue_nxt;

	assign hue_sum = {1'b0, hue_q} + {1'b0, hue_step_q};
	assign hue_mod = (hue_sum >= lbp_pkg::HUE_WRAP_TWICE) ? hue_sum - lbp_pkg::HUE_WRAP_TWICE :
		(hue_sum >= {1'b0, lbp_pkg::HUE_WRAP}) ? hue_sum - {1'b0, lbp_pkg::HUE_WRAP} : hue_sum;
	assign hue_nxt = hue_mod[8:0];

	// green channel at full saturation: v * frac / 255 on the rising edge,
	// v * (255 - frac) / 255 on the falling edge
	logic [7:0]  g_op;
	logic [15:0] g_prod;
	logic [16:0] g_sum;
	logic [7:0]  g_scaled;
	logic [7:0]  green;

	assign g_op     = (hpos_q.sext == lbp_pkg::SEXT_G_FALL) ? 8'd255 - hpos_q.frac : hpos_q.frac;
	assign g_prod   = bright_q * g_op;
	// exact x / 255 for x up to 255 * 255, the largest product
	assign g_sum    = {1'b0, g_prod} + {9'd0, g_prod[15:8]} + 17'd1;
	assign g_scaled = g_sum[15:8];

	always_comb begin
		case (hpos_q.sext)
			lbp_pkg::SEXT_G_RISE:   green = g_scaled;
			lbp_pkg::SEXT_G_FULL_A: green = bright_q;
			lbp_pkg::SEXT_G_FULL_B: green = bright_q;
			lbp_pkg::SEXT_G_FALL:   green = g_scaled;
			default:                green = 8'd0;
		endcase
	end

	// result fields
	logic [7:0] duty_d;
	logic       dv_d;
	logic [5:0] fade_d;
	logic [9:0] hold_d;

	// helpers for the step logic
	logic [7:0] slice;
	logic [8:0] b_sum;
	logic [8:0] r_sum;
	logic [7:0] r_sat;
	logic [7:0] r_diff;
	logic [7:0] bstep8;
	logic [7:0] rstep8;

	assign slice  = (flash_slice_q == 8'd0) ? 8'd1 : flash_slice_q;
	assign bstep8 = {1'b0, breath_step_q};
	assign rstep8 = {1'b0, rainbow_step_q};
	assign b_sum  = {1'b0, bright_q} + {1'b0, bstep8};
	assign r_sum  = {1'b0, bright_q} + {1'b0, rstep8};
	assign r_sat  = r_sum[8] ? 8'd255 : r_sum[7:0];
	assign r_diff = (bright_q > rstep8) ? bright_q - rstep8 : 8'd0;

	always_comb begin
		pat_d    = pattern_q;
		hue_d    = hue_q;
		hpos_d   = hpos_q;
		bright_d = bright_q;
		up_d     = up_q;
		flash_d  = flash_q;
		duty_d   = 8'd0;
		dv_d     = 1'b0;
		fade_d   = 6'd0;
		hold_d   = 10'd0;
		case (mode_s1)
			lbp_pkg::MODE_SET: begin
				if (value_s1 <= 16'd1) begin
					if (value_s1[0]) begin
						pat_d = lbp_pkg::PAT_RAINBOW;
					end else begin
						pat_d = lbp_pkg::PAT_BREATH;
					end
				end
			end
			lbp_pkg::MODE_FLASH: begin
				flash_d = value_s1;
				pat_d   = lbp_pkg::PAT_FLASH;
			end
			lbp_pkg::MODE_TICK: begin
				case (pattern_q)
					lbp_pkg::PAT_FLASH: begin
						if (flash_q != 16'd0) begin
							duty_d = lbp_pkg::FULL_DUTY;
							dv_d   = 1'b1;
							fade_d = lbp_pkg::FADE_FLASH;
							if (flash_q > {8'd0, slice}) begin
								hold_d  = {2'd0, slice};
								flash_d = flash_q - {8'd0, slice};
							end else begin
								// last slice: what is left fits in 8 bits
								hold_d  = {2'd0, flash_q[7:0]};
								flash_d = 16'd0;
								pat_d   = lbp_pkg::PAT_BREATH;
							end
						end else begin
							pat_d = lbp_pkg::PAT_BREATH;
						end
					end
					lbp_pkg::PAT_BREATH: begin
						duty_d = lbp_pkg::clamp_duty(bright_q);
						dv_d   = 1'b1;
						fade_d = lbp_pkg::FADE_BREATH;
						if (up_q) begin
							if (b_sum >= 9'd255) begin
								bright_d = 8'd255;
								up_d     = 1'b0;
								hold_d   = breath_pause_q;
							end else begin
								bright_d = b_sum[7:0];
							end
						end else begin
							if (bright_q <= bstep8) begin
								bright_d = 8'd0;
								up_d     = 1'b1;
								hold_d   = breath_pause_q;
							end else begin
								bright_d = bright_q - bstep8;
							end
						end
					end
					lbp_pkg::PAT_RAINBOW: begin
						duty_d = lbp_pkg::clamp_duty(green);
						dv_d   = 1'b1;
						fade_d = lbp_pkg::FADE_RAINBOW;
						hue_d  = hue_nxt;
						hpos_d = lbp_pkg::hue_split(hue_nxt);
						if (up_q) begin
							if (r_sat >= rainbow_max_q) begin
								bright_d = rainbow_max_q;
								up_d     = 1'b0;
							end else begin
								bright_d = r_sat;
							end
						end else begin
							// subtract first, then clamp to the lower bound
							if (r_diff <= rainbow_min_q) begin
								bright_d = rainbow_min_q;
								up_d     = 1'b1;
							end else begin
								bright_d = r_diff;
							end
						end
					end
					default: ;
				endcase
			end
			default: ; // unused mode: no state change, no duty
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= lbp_pkg::PAT_BREATH;
			hue_q       <= 9'd0;
			hpos_q.sext <= lbp_pkg::SEXT_G_RISE;
			hpos_q.frac <= 8'd0;
			bright_q    <= 8'd128;
			up_q        <= 1'b1;
			flash_q     <= 16'd0;
		end else if (adv) begin
			pattern_q <= pat_d;
			hue_q     <= hue_d;
			hpos_q    <= hpos_d;
			bright_q  <= bright_d;
			up_q      <= up_d;
			flash_q   <= flash_d;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic [7:0] duty_s2;
	logic       dv_s2;
	logic [5:0] fade_s2;
	logic [9:0] hold_s2;
	logic [1:0] pat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s2 <= 1'b0;
		end else if (adv) begin
			out_v_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			duty_s2 <= duty_d;
			dv_s2   <= dv_d;
			fade_s2 <= fade_d;
			hold_s2 <= hold_d;
			pat_s2  <= pat_d;
		end
	end

	assign out_valid   = out_v_s2;
	assign duty        = duty_s2;
	assign duty_valid  = dv_s2;
	assign fade_ms     = fade_s2;
	assign hold_ms     = hold_s2;
	assign pattern_now = pat_s2;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// hue stays on the circle
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hue_q < lbp_pkg::HUE_WRAP)
		else $error("hue left the 0..359 range");

	// a request that leaves the input register shows up as a result next cycle
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced request produced no result");

	// results without a duty target carry all-zero timing fields
	a_no_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !duty_valid) |-> (duty == 8'd0 && fade_ms == 6'd0 && hold_ms == 10'd0))
		else $error("result without duty carries nonzero fields");

	// a flash duty is always full scale with the short fade
	a_flash_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && duty_valid && fade_ms == lbp_pkg::FADE_FLASH)
			|-> (duty == lbp_pkg::FULL_DUTY && hold_ms != 10'd0))
		else $error("flash result with wrong duty or zero slice");

endmodule

[test/led_breathing_pattern_generator_test.sv]
`timescale 1ns / 1ps

module led_breathing_pattern_generator_test;

	// one result of the block, as predicted or as seen on the result port
	typedef struct packed {
		logic [7:0] duty;
		logic       dv;
		logic [5:0] fade;
		logic [9:0] hold;
		logic [1:0] pat;
	} led_result_t;

	localparam int HOLD_OFF_LEN  = 80;   // cycles the receiver refuses results
	localparam int PHASE_ITEMS   = 120;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [1:0]  mode      = lbp_pkg::MODE_TICK;
	logic [15:0] value     = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  duty;
	logic        duty_valid;
	logic [5:0]  fade_ms;
	logic [9:0]  hold_ms;
	logic [1:0]  pattern_now;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = lbp_pkg::REG_BREATH_STEP;
	logic [9:0]  cfg_data  = '0;

	led_breathing_pattern_generator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.duty       (duty),
		.duty_valid (duty_valid),
		.fade_ms    (fade_ms),
		.hold_ms    (hold_ms),
		.pattern_now(pattern_now),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// Predictor: private copy of the registers and the pattern state.
	// ---------------------------------------------------------------
	logic [6:0] cfg_breath_step;
	logic [6:0] cfg_rainbow_step;
	logic [8:0] cfg_hue_step;
	logic [7:0] cfg_rainbow_max;
	logic [7:0] cfg_rainbow_min;
	logic [7:0] cfg_flash_slice;
	logic [9:0] cfg_breath_pause;

	lbp_pkg::pattern_t cur_pat;
	int unsigned cur_hue;
	int unsigned cur_bright;    // wide so a step can overshoot before saturating
	bit          rising;
	int unsigned flash_left;

	led_result_t led_targets_due[$];   // one entry per accepted request
	int          mismatches = 0;

	bit tx_idle_en = 1'b1;             // sender inserts gaps between requests
	bit rx_idle_en = 1'b1;             // receiver stalls at random
	int hold_off_cycles = 0;           // nonzero asks the receiver for a long hold-off

	task automatic reset_pattern_state;
		cfg_breath_step  = 7'd4;
		cfg_rainbow_step = 7'd2;
		cfg_hue_step     = 9'd3;
		cfg_rainbow_max  = 8'd200;
		cfg_rainbow_min  = 8'd30;
		cfg_flash_slice  = 8'd50;
		cfg_breath_pause = 10'd300;
		cur_pat    = lbp_pkg::PAT_BREATH;
		cur_hue    = 0;
		cur_bright = 128;
		rising     = 1'b1;
		flash_left = 0;
	endtask

	function automatic logic [7:0] duty_cap(int unsigned d);
		return (d > lbp_pkg::FULL_DUTY) ? lbp_pkg::FULL_DUTY : 8'(d);
	endfunction

	// green channel of a full-saturation HSV color, hue below 360
	function automatic int unsigned hsv_green(int unsigned h, int unsigned v);
		int unsigned sector;
		int unsigned frac;
		sector = h / 60;
		frac = (h - sector * 60) * 255 / 60;
		case (sector)
		0: return v * frac / 255;
		1, 2: return v;
		3: return v * (255 - frac) / 255;
		default: return 0;
		endcase
	endfunction

	// apply one request to the predicted state and return the expected result
	task automatic advance_pattern(input lbp_pkg::mode_t m, input logic [15:0] v,
		output led_result_t r);
		int unsigned slice;
		r = '0;
		case (m)
		lbp_pkg::MODE_SET: begin
			if (v <= 16'd1) begin
				if (v == 16'd1)
					cur_pat = lbp_pkg::PAT_RAINBOW;
				else
					cur_pat = lbp_pkg::PAT_BREATH;
			end
		end
		lbp_pkg::MODE_FLASH: begin
			flash_left = v;
			cur_pat = lbp_pkg::PAT_FLASH;
		end
		lbp_pkg::MODE_TICK: begin
			case (cur_pat)
			lbp_pkg::PAT_FLASH: begin
				if (flash_left > 0) begin
					// zero slice counts as 1 ms so the flash always ends
					slice = (cfg_flash_slice == 0) ? 1 : cfg_flash_slice;
					r.duty = lbp_pkg::FULL_DUTY;
					r.dv   = 1'b1;
					r.fade = lbp_pkg::FADE_FLASH;
					if (flash_left > slice) begin
						r.hold = 10'(slice);
						flash_left = flash_left - slice;
					end else begin
						r.hold = 10'(flash_left);
						flash_left = 0;
						cur_pat = lbp_pkg::PAT_BREATH;
					end
				end else begin
					cur_pat = lbp_pkg::PAT_BREATH;
				end
			end
			lbp_pkg::PAT_BREATH: begin
				r.duty = duty_cap(cur_bright);
				r.dv   = 1'b1;
				r.fade = lbp_pkg::FADE_BREATH;
				if (rising) begin
					cur_bright = cur_bright + cfg_breath_step;
					if (cur_bright >= 255) begin
						cur_bright = 255;
						rising = 1'b0;
						r.hold = cfg_breath_pause;
					end
				end else if (cur_bright <= cfg_breath_step) begin
					cur_bright = 0;
					rising = 1'b1;
					r.hold = cfg_breath_pause;
				end else begin
					cur_bright = cur_bright - cfg_breath_step;
				end
			end
			default: begin
				r.duty = duty_cap(hsv_green(cur_hue, cur_bright));
				r.dv   = 1'b1;
				r.fade = lbp_pkg::FADE_RAINBOW;
				cur_hue = (cur_hue + cfg_hue_step) % 360;
				if (rising) begin
					cur_bright = cur_bright + cfg_rainbow_step;
					if (cur_bright > 255)
						cur_bright = 255;
					if (cur_bright >= cfg_rainbow_max) begin
						cur_bright = cfg_rainbow_max;
						rising = 1'b0;
					end
				end else begin
					// subtract first, then clamp to the lower bound
					cur_bright = (cur_bright > cfg_rainbow_step) ?
						cur_bright - cfg_rainbow_step : 0;
					if (cur_bright <= cfg_rainbow_min) begin
						cur_bright = cfg_rainbow_min;
						rising = 1'b1;
					end
				end
			end
			endcase
		end
		default: ;   // unused mode: no state change
		endcase
		r.pat = cur_pat;
	endtask

	// ---------------------------------------------------------------
	// Result checking: every accepted result against the oldest prediction.
	// ---------------------------------------------------------------
	task automatic flag_field(string field, int unsigned want, int unsigned got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	task automatic check_result;
		led_result_t want;
		if (led_targets_due.size() == 0) begin
			mismatches++;
			$display("%0t: result with no request pending, expected none, actual duty %0d",
				$time, duty);
		end else begin
			want = led_targets_due.pop_front();
			if (duty !== want.duty)
				flag_field("duty", want.duty, duty);
			if (duty_valid !== want.dv)
				flag_field("duty_valid", want.dv, duty_valid);
			if (fade_ms !== want.fade)
				flag_field("fade_ms", want.fade, fade_ms);
			if (hold_ms !== want.hold)
				flag_field("hold_ms", want.hold, hold_ms);
			if (pattern_now !== want.pat)
				flag_field("pattern_now", want.pat, pattern_now);
		end
	endtask

	// values seen right after the edge are the ones the edge sampled
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap;
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Receiver pacing. A long hold-off is counted here so that the sender
	// keeps pushing requests until the block backs up and stalls its input.
	always begin : rx_pacing
		int n;
		@(posedge clk);
		if (hold_off_cycles > 0) begin
			n = hold_off_cycles;
			out_stall <= 1'b1;
			repeat (n) @(posedge clk);
			hold_off_cycles = 0;
			out_stall <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
			n = 1 + pick_gap();
			out_stall <= 1'b1;
			repeat (n) @(posedge clk);
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Request and register traffic
	// ---------------------------------------------------------------

	// Offer one request, wait until taken, record its prediction, then idle.
	// in_valid is only lowered when a gap follows, so back-to-back requests
	// never see a low and a high assignment in the same step.
	task automatic send_request(input lbp_pkg::mode_t m, input logic [15:0] v, input int gap);
		led_result_t r;
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_pattern(m, v, r);
		led_targets_due.push_back(r);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int tx_gap;
		return tx_idle_en ? pick_gap() : 0;
	endfunction

	// sender pauses until every predicted result has been seen
	task automatic wait_drained;
		in_valid <= 1'b0;
		while (led_targets_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input lbp_pkg::cfg_reg_t idx, input logic [9:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		lbp_pkg::REG_BREATH_STEP:  cfg_breath_step  = d[6:0];
		lbp_pkg::REG_RAINBOW_STEP: cfg_rainbow_step = d[6:0];
		lbp_pkg::REG_HUE_STEP:     cfg_hue_step     = d[8:0];
		lbp_pkg::REG_RAINBOW_MAX:  cfg_rainbow_max  = d[7:0];
		lbp_pkg::REG_RAINBOW_MIN:  cfg_rainbow_min  = d[7:0];
		lbp_pkg::REG_FLASH_SLICE:  cfg_flash_slice  = d[7:0];
		default:                   cfg_breath_pause = d;
		endcase
	endtask

	// all seven registers, only ever called with the block idle
	task automatic set_config(input int unsigned bstep, input int unsigned rstep,
		input int unsigned hstep, input int unsigned rmax, input int unsigned rmin,
		input int unsigned slice, input int unsigned pause);
		write_reg(lbp_pkg::REG_BREATH_STEP, 10'(bstep));
		write_reg(lbp_pkg::REG_RAINBOW_STEP, 10'(rstep));
		write_reg(lbp_pkg::REG_HUE_STEP, 10'(hstep));
		write_reg(lbp_pkg::REG_RAINBOW_MAX, 10'(rmax));
		write_reg(lbp_pkg::REG_RAINBOW_MIN, 10'(rmin));
		write_reg(lbp_pkg::REG_FLASH_SLICE, 10'(slice));
		write_reg(lbp_pkg::REG_BREATH_PAUSE, 10'(pause));
		cfg_valid <= 1'b0;
	endtask

	task automatic random_config(input bit crossed);
		int unsigned lo;
		int unsigned hi;
		int unsigned t;
		lo = $urandom_range(0, 255);
		hi = $urandom_range(0, 255);
		if ((lo > hi) != crossed) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		set_config($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 511),
			hi, lo, $urandom_range(0, 255), $urandom_range(0, 1023));
	endtask

	// Random requests, weighted toward ticks so patterns run deep; count
	// covers requests that change or report something, not ignored ones.
	task automatic send_random(input int count);
		int done;
		int r;
		logic [15:0] v;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 99);
			v = 16'($urandom);
			if (r < 62) begin
				send_request(lbp_pkg::MODE_TICK, v, tx_gap());
				done++;
			end else if (r < 72) begin
				send_request(lbp_pkg::MODE_SET, 16'($urandom_range(0, 1)), tx_gap());
				done++;
			end else if (r < 75) begin
				send_request(lbp_pkg::MODE_SET, v, tx_gap());
				if (v <= 16'd1)
					done++;
			end else if (r < 84) begin
				send_request(lbp_pkg::MODE_FLASH, 16'($urandom_range(0, 400)), tx_gap());
				done++;
			end else if (r < 87) begin
				send_request(lbp_pkg::MODE_FLASH, v, tx_gap());
				done++;
			end else if (r < 90) begin
				send_request(lbp_pkg::MODE_FLASH, 16'd0, tx_gap());
				done++;
			end else begin
				send_request(lbp_pkg::MODE_NONE, v, tx_gap());
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Extreme register values; walk breathing through both turns, rainbow
	// up to saturation, ignored requests, and flash with a zero slice.
	task automatic test_directed;
		set_config(127, 64, 359, 255, 0, 0, 1023);
		// 128 -> 255 -> 128 -> 1 -> 0
		repeat (5) send_request(lbp_pkg::MODE_TICK, 16'd0, tx_gap());
		send_request(lbp_pkg::MODE_SET, 16'd1, tx_gap());
		repeat (4) send_request(lbp_pkg::MODE_TICK, 16'hFFFF, tx_gap());
		send_request(lbp_pkg::MODE_SET, 16'hFFFF, tx_gap());      // pattern number too large
		send_request(lbp_pkg::MODE_NONE, 16'hFFFF, tx_gap());     // unused mode
		send_request(lbp_pkg::MODE_FLASH, 16'd3, tx_gap());       // 1 ms slices: three ticks
		repeat (4) send_request(lbp_pkg::MODE_TICK, 16'd0, tx_gap());
		send_request(lbp_pkg::MODE_FLASH, 16'd0, tx_gap());
		send_request(lbp_pkg::MODE_TICK, 16'd0, tx_gap());        // no flash time: back to breath
		send_request(lbp_pkg::MODE_FLASH, 16'hFFFF, tx_gap());
		send_request(lbp_pkg::MODE_TICK, 16'd0, tx_gap());
		send_request(lbp_pkg::MODE_SET, 16'd0, tx_gap());
		send_request(lbp_pkg::MODE_TICK, 16'd0, tx_gap());
		wait_drained();
	endtask

	// Receiver holds off while requests keep coming, so both pipeline
	// registers fill and the input stalls; then the sender waits it out.
	task automatic test_backpressure;
		set_config(4, 2, 3, 200, 30, 50, 300);
		send_request(lbp_pkg::MODE_SET, 16'd1, 0);
		hold_off_cycles = HOLD_OFF_LEN;
		repeat (24) send_request(lbp_pkg::MODE_TICK, 16'd0, 0);
		wait_drained();
		send_request(lbp_pkg::MODE_FLASH, 16'd120, 0);
		hold_off_cycles = HOLD_OFF_LEN;
		repeat (12) send_request(lbp_pkg::MODE_TICK, 16'd0, 0);
		wait_drained();
	endtask

	// Several register settings, each followed by a random request stream.
	task automatic test_random_phases;
		// smallest steps and bounds
		set_config(1, 1, 0, 0, 0, 1, 0);
		send_random(PHASE_ITEMS);
		wait_drained();
		// rainbow bounds crossed
		random_config(1'b1);
		send_random(PHASE_ITEMS);
		wait_drained();
		// a stretch with no idling on either side
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		random_config(1'b0);
		send_random(PHASE_ITEMS);
		wait_drained();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (3) begin
			random_config($urandom_range(0, 4) == 0);
			send_random(PHASE_ITEMS);
			wait_drained();
		end
	endtask

	// drain with a bound, then watch for stray results
	task automatic drain_at_end;
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (led_targets_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (led_targets_due.size() != 0) begin
			mismatches++;
			$display("%0t: %0d results never arrived, expected 0 pending, actual %0d",
				$time, led_targets_due.size(), led_targets_due.size());
		end
	endtask

	initial begin
		reset_pattern_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_phases();
		drain_at_end();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// run limit well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/lbp_pkg.sv
rtl/core/led_breathing_pattern_generator.sv
test/led_breathing_pattern_generator_test.sv
